/* src/pfes_pkg.sv */
// Shared types, constants and fixed-point helpers of the phase-field stencil core.
package pfes_pkg;

  localparam int FRAC_BITS = 24;
  localparam int DW        = 32;
  localparam int GW        = 48;
  localparam int SW        = 39;  // exact stencil sum
  localparam int MW        = 41;  // scaled magnitude, capped at 2^40
  localparam int PW        = 72;  // multiplier product
  localparam int LINES     = 4;
  localparam int WIN       = 5;

  localparam logic [2:0] REG_FIRST_STEP = 3'd0;
  localparam logic [2:0] REG_BETA       = 3'd1;
  localparam logic [2:0] REG_LAP_GAIN   = 3'd2;
  localparam logic [2:0] REG_BILAP_GAIN = 3'd3;
  localparam logic [2:0] REG_GRID_COLS  = 3'd4;
  localparam logic [2:0] REG_GRID_ROWS  = 3'd5;

  typedef enum logic [2:0] {
    S_CLR, S_IN, S_RD, S_GO, S_CALC, S_DONE
  } ctl_state_t;

  typedef enum logic [3:0] {
    A_IDLE, A_SQ, A_SQW, A_LIN, A_LINW, A_G0, A_G1, A_G2, A_G3, A_G4, A_FIN
  } arith_state_t;

  typedef struct packed {
    logic                 first_step;
    logic signed [DW-1:0] beta;
    logic [GW-1:0]        lap_gain;
    logic [GW-1:0]        bilap_gain;
  } coef_t;

  typedef struct packed {
    logic signed [DW-1:0] n2, s2, w2, e2;
    logic signed [DW-1:0] nw, ne, sw, se;
    logic signed [DW-1:0] n, s, w, e;
    logic signed [DW-1:0] c;
  } stencil_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[DW-1:0];
    end
  endfunction

  // round half up, then drop the fraction bits
  function automatic logic signed [63:0] rnd(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] t;
    t = (x + (72'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return t[63:0];
  endfunction

endpackage

/* src/pfes_line_mem.sv */
// Line store: four earlier padded lines packed into one word per column.
module pfes_line_mem #(
  parameter int DEPTH = 1028,
  parameter int AW    = 11,
  parameter int W     = 128
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/pfes_arith.sv */
// Sequenced arithmetic: nonlinear term, Laplacian, biharmonic and gain scaling on one multiplier.
module pfes_arith (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  pfes_pkg::coef_t              coef,
  input  pfes_pkg::stencil_t           pts,
  output logic                         done,
  output logic signed [pfes_pkg::DW-1:0] explicit_value,
  output logic signed [pfes_pkg::DW-1:0] sum_value
);

  localparam int DW = pfes_pkg::DW;
  localparam int SW = pfes_pkg::SW;
  localparam int MW = pfes_pkg::MW;
  localparam int PW = pfes_pkg::PW;
  localparam int F  = pfes_pkg::FRAC_BITS;
  localparam logic [MW-1:0] MAG_CAP = MW'(1) << 40;
  localparam logic signed [63:0] ONE = 64'sd1 <<< F;

  pfes_pkg::arith_state_t state_r, state_nxt;

  logic signed [PW-1:0] prod_r;
  logic signed [SW-1:0] lap_r, bl_r;
  logic signed [DW-1:0] phi_r, a_r, ex_r, sm_r;
  logic [MW-1:0]        hi_r;
  logic [2:0]           k_r;

  logic signed [SW-1:0] mul_a;
  logic signed [32:0]   mul_b;
  logic                 neg_sel;
  logic signed [DW-1:0] p_sel, p2, v;
  logic signed [SW-1:0] bl_sum, lap_mag, bl_mag;
  logic [MW-1:0]        hi_cap, mag;
  logic [62:0]          lo_sum;
  logic [62-F:0]        lo_sh;
  logic [MW:0]          m_sum;
  logic signed [MW+1:0] dlt;
  logic signed [DW-1:0] applied;

  always_comb begin
    case (k_r)
      3'd0:    p_sel = pts.n;
      3'd1:    p_sel = pts.s;
      3'd2:    p_sel = pts.w;
      3'd3:    p_sel = pts.e;
      default: p_sel = pts.c;
    endcase
  end

  assign bl_sum = SW'(pts.n2) + SW'(pts.s2) + SW'(pts.w2) + SW'(pts.e2)
                + ((SW'(pts.nw) + SW'(pts.ne) + SW'(pts.sw) + SW'(pts.se)) <<< 1)
                - ((SW'(pts.n) + SW'(pts.s) + SW'(pts.w) + SW'(pts.e)) <<< 3)
                + (SW'(pts.c) <<< 4) + (SW'(pts.c) <<< 2);

  assign lap_mag = lap_r[SW-1] ? -lap_r : lap_r;
  assign bl_mag  = bl_r[SW-1] ? -bl_r : bl_r;

  assign p2 = pfes_pkg::sat32(pfes_pkg::rnd(prod_r));
  assign v  = p2;

  // products in the gain steps are never negative
  assign hi_cap = (prod_r > PW'(MAG_CAP)) ? MAG_CAP : prod_r[MW-1:0];
  assign lo_sum = {1'b0, prod_r[61:0]} + (63'd1 << (F - 1));
  assign lo_sh  = lo_sum[62:F];
  assign m_sum  = (MW+1)'(hi_r) + (MW+1)'(lo_sh);
  assign mag    = (m_sum > (MW+1)'(MAG_CAP)) ? MAG_CAP : m_sum[MW-1:0];
  assign dlt    = neg_sel ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
  assign applied = pfes_pkg::sat32(64'(phi_r) + 64'(dlt));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfes_pkg::A_IDLE: if (start) begin
        state_nxt = coef.first_step ? pfes_pkg::A_FIN : pfes_pkg::A_SQ;
      end
      pfes_pkg::A_SQ:   state_nxt = pfes_pkg::A_SQW;
      pfes_pkg::A_SQW:  state_nxt = pfes_pkg::A_LIN;
      pfes_pkg::A_LIN:  state_nxt = pfes_pkg::A_LINW;
      pfes_pkg::A_LINW: state_nxt = (k_r == 3'd4) ? pfes_pkg::A_G0 : pfes_pkg::A_SQ;
      pfes_pkg::A_G0:   state_nxt = pfes_pkg::A_G1;
      pfes_pkg::A_G1:   state_nxt = pfes_pkg::A_G2;
      pfes_pkg::A_G2:   state_nxt = pfes_pkg::A_G3;
      pfes_pkg::A_G3:   state_nxt = pfes_pkg::A_G4;
      pfes_pkg::A_G4:   state_nxt = pfes_pkg::A_FIN;
      pfes_pkg::A_FIN:  state_nxt = pfes_pkg::A_IDLE;
      default:          state_nxt = pfes_pkg::A_IDLE;
    endcase
  end

  always_comb begin
    mul_a   = SW'(p_sel);
    mul_b   = 33'(p_sel);
    neg_sel = 1'b0;
    done    = 1'b0;
    case (state_r)
      pfes_pkg::A_LIN: mul_a = SW'(a_r);
      pfes_pkg::A_G0: begin
        mul_a = lap_mag;
        mul_b = $signed({9'd0, coef.lap_gain[47:F]});
      end
      pfes_pkg::A_G1: begin
        mul_a = lap_mag;
        mul_b = $signed({9'd0, coef.lap_gain[F-1:0]});
      end
      pfes_pkg::A_G2: begin
        mul_a   = bl_mag;
        mul_b   = $signed({9'd0, coef.bilap_gain[47:F]});
        neg_sel = lap_r[SW-1];
      end
      pfes_pkg::A_G3: begin
        mul_a = bl_mag;
        mul_b = $signed({9'd0, coef.bilap_gain[F-1:0]});
      end
      pfes_pkg::A_G4: neg_sel = ~bl_r[SW-1];
      pfes_pkg::A_FIN: done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfes_pkg::A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      pfes_pkg::A_IDLE: if (start) begin
        k_r   <= 3'd0;
        lap_r <= '0;
        bl_r  <= bl_sum;
        phi_r <= pts.c;
        ex_r  <= pts.c;
        sm_r  <= pts.c;
      end
      pfes_pkg::A_SQW:  a_r <= pfes_pkg::sat32(64'(p2) - ONE - 64'(coef.beta));
      pfes_pkg::A_LINW: begin
        lap_r <= (k_r == 3'd4) ? lap_r - (SW'(v) <<< 2) : lap_r + SW'(v);
        k_r   <= k_r + 3'd1;
      end
      pfes_pkg::A_G1:   hi_r <= hi_cap;
      pfes_pkg::A_G2:   ex_r <= applied;
      pfes_pkg::A_G3:   hi_r <= hi_cap;
      pfes_pkg::A_G4:   sm_r <= applied;
      default: ;
    endcase
  end

  assign explicit_value = ex_r;
  assign sum_value      = sm_r;

endmodule

/* src/phase_field_explicit_stencil_core.sv */
// Top level: raster counters, 5x5 window, line store control and result register.
// Each sample is accepted, then written back into its line store column (read-modify-write);
// an interior point then runs the arithmetic, the single shared multiplier doing 14 products
// in turn (skipped in first-step mode); no new sample is accepted until its result is loaded.
// Reset: synchronous active low; then a clearing pass zeroes all MAX_COLS+4 line store
// addresses, during which no item is accepted (configuration writes still land).
module phase_field_explicit_stencil_core #(
  parameter int MAX_COLS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_field_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_explicit_value,
  output logic [31:0] out_sum_value,
  output logic        out_frame_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int DW       = pfes_pkg::DW;
  localparam int LINE_LEN = MAX_COLS + 4;
  localparam int AW       = $clog2(LINE_LEN);
  localparam int MEMW     = pfes_pkg::LINES * DW;
  localparam int COLS_RST = (MAX_COLS < 1024) ? MAX_COLS : 1024;
  localparam logic [AW-1:0] LAST_ADDR = AW'(LINE_LEN - 1);

  pfes_pkg::ctl_state_t state_r, state_nxt;

  logic                 first_step_r;
  logic signed [DW-1:0] beta_r;
  logic [47:0]          lap_gain_r, bilap_gain_r;
  logic [AW-1:0]        cols_r;
  logic [12:0]          rows_r;

  logic [AW-1:0] col_r, clr_addr_r, c_r;
  logic [13:0]   row_r;
  logic [DW-1:0] x_r;
  logic          produce_r, last_r;
  logic signed [DW-1:0] win_r [pfes_pkg::WIN][pfes_pkg::WIN];

  logic [DW-1:0] ex_out_r, sm_out_r;
  logic          out_valid_r, last_out_r;

  logic            accept, mem_we, start, load_out, calc_done;
  logic [AW-1:0]   waddr;
  logic [MEMW-1:0] wdata, rdata;
  logic [AW:0]     width;
  logic [13:0]     height;
  logic            last_pt, produce_pt;
  logic [31:0]     cols_req;
  logic [12:0]     rows_req;

  pfes_pkg::coef_t    coef;
  pfes_pkg::stencil_t pts;
  logic signed [DW-1:0] calc_ex, calc_sm;

  assign accept = in_valid & in_ready;
  assign width  = (AW+1)'(cols_r) + (AW+1)'(4);
  assign height = 14'(rows_r) + 14'd4;
  assign last_pt    = (row_r == height - 14'd1) && ((AW+1)'(col_r) == width - (AW+1)'(1));
  assign produce_pt = (row_r >= 14'd4) && (col_r >= AW'(4));

  always_comb begin
    cols_req = 32'(cfg_data[10:0]);
    if (cols_req == 32'd0) begin
      cols_req = 32'd1;
    end else if (cols_req > 32'(MAX_COLS)) begin
      cols_req = 32'(MAX_COLS);
    end
    rows_req = cfg_data[12:0];
    if (rows_req == 13'd0) begin
      rows_req = 13'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_step_r <= 1'b0;
      beta_r       <= '0;
      lap_gain_r   <= '0;
      bilap_gain_r <= '0;
      cols_r       <= AW'(COLS_RST);
      rows_r       <= 13'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        pfes_pkg::REG_FIRST_STEP: first_step_r <= cfg_data[0];
        pfes_pkg::REG_BETA:       beta_r       <= cfg_data[31:0];
        pfes_pkg::REG_LAP_GAIN:   lap_gain_r   <= cfg_data;
        pfes_pkg::REG_BILAP_GAIN: bilap_gain_r <= cfg_data;
        pfes_pkg::REG_GRID_COLS:  cols_r       <= cols_req[AW-1:0];
        pfes_pkg::REG_GRID_ROWS:  rows_r       <= rows_req;
        default: ;
      endcase
    end
  end

  // raster position of the next sample; a size write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_we && (cfg_index == pfes_pkg::REG_GRID_COLS ||
                            cfg_index == pfes_pkg::REG_GRID_ROWS)) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (last_pt || row_r >= height) begin
        col_r <= '0;
        row_r <= '0;
      end else if ((AW+1)'(col_r) + (AW+1)'(1) >= width) begin
        col_r <= '0;
        row_r <= row_r + 14'd1;
      end else begin
        col_r <= col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r       <= in_field_value;
      c_r       <= col_r;
      produce_r <= produce_pt;
      last_r    <= last_pt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (state_r == pfes_pkg::S_CLR) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfes_pkg::S_CLR:  if (clr_addr_r == LAST_ADDR) state_nxt = pfes_pkg::S_IN;
      pfes_pkg::S_IN:   if (in_valid) state_nxt = pfes_pkg::S_RD;
      pfes_pkg::S_RD:   state_nxt = produce_r ? pfes_pkg::S_GO : pfes_pkg::S_IN;
      pfes_pkg::S_GO:   state_nxt = pfes_pkg::S_CALC;
      pfes_pkg::S_CALC: if (calc_done) state_nxt = pfes_pkg::S_DONE;
      pfes_pkg::S_DONE: if (!out_valid_r || out_ready) state_nxt = pfes_pkg::S_IN;
      default:          state_nxt = pfes_pkg::S_CLR;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    start    = 1'b0;
    load_out = 1'b0;
    waddr    = c_r;
    wdata    = {x_r, rdata[MEMW-1:DW]};
    case (state_r)
      pfes_pkg::S_CLR: begin
        mem_we = 1'b1;
        waddr  = clr_addr_r;
        wdata  = '0;
      end
      pfes_pkg::S_IN:   in_ready = 1'b1;
      pfes_pkg::S_RD:   mem_we   = 1'b1;
      pfes_pkg::S_GO:   start    = 1'b1;
      pfes_pkg::S_DONE: load_out = ~out_valid_r | out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfes_pkg::S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  pfes_line_mem #(
    .DEPTH(LINE_LEN),
    .AW   (AW),
    .W    (MEMW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (accept),
    .raddr(col_r),
    .rdata(rdata)
  );

  // advance the window by one column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pfes_pkg::WIN; i++) begin
        for (int j = 0; j < pfes_pkg::WIN; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (state_r == pfes_pkg::S_RD) begin
      for (int i = 0; i < pfes_pkg::WIN; i++) begin
        for (int j = 0; j < pfes_pkg::WIN - 1; j++) begin
          win_r[i][j] <= win_r[i][j+1];
        end
      end
      for (int i = 0; i < pfes_pkg::LINES; i++) begin
        win_r[i][pfes_pkg::WIN-1] <= rdata[i*DW +: DW];
      end
      win_r[pfes_pkg::WIN-1][pfes_pkg::WIN-1] <= x_r;
    end
  end

  assign pts.n2 = win_r[0][2];
  assign pts.s2 = win_r[4][2];
  assign pts.w2 = win_r[2][0];
  assign pts.e2 = win_r[2][4];
  assign pts.nw = win_r[1][1];
  assign pts.ne = win_r[1][3];
  assign pts.sw = win_r[3][1];
  assign pts.se = win_r[3][3];
  assign pts.n  = win_r[1][2];
  assign pts.s  = win_r[3][2];
  assign pts.w  = win_r[2][1];
  assign pts.e  = win_r[2][3];
  assign pts.c  = win_r[2][2];

  assign coef.first_step = first_step_r;
  assign coef.beta       = beta_r;
  assign coef.lap_gain   = lap_gain_r;
  assign coef.bilap_gain = bilap_gain_r;

  pfes_arith u_arith (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .coef          (coef),
    .pts           (pts),
    .done          (calc_done),
    .explicit_value(calc_ex),
    .sum_value     (calc_sm)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ex_out_r   <= calc_ex;
      sm_out_r   <= calc_sm;
      last_out_r <= last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_explicit_value = ex_out_r;
  assign out_sum_value      = sm_out_r;
  assign out_frame_last     = last_out_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pfes_pkg::S_CLR) |-> !in_ready)
    else $error("item accepted during line store clear");

  a_done_only_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    calc_done |-> (state_r == pfes_pkg::S_CALC))
    else $error("arithmetic finished outside calc state");

  a_mem_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == pfes_pkg::S_RD || state_r == pfes_pkg::S_CLR))
    else $error("line store written outside write-back or clear");

  a_rd_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == pfes_pkg::S_RD))
    else $error("accepted item not followed by line read");

endmodule

/* test/tb_phase_field_explicit_stencil_core.sv */
// Testbench for the phase-field stencil core: streams padded grids and checks every point.
`timescale 1ns / 1ps

module tb_phase_field_explicit_stencil_core;

  localparam int TOTAL_ITEMS = 1450;
  localparam int STALL_LIMIT = 6000;
  localparam int SETTLE      = 50;
  localparam int LINE_LEN    = 1024 + 4;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  class stencil_scoreboard;
    typedef struct packed {
      logic [31:0] ex;
      logic [31:0] sm;
      logic        last;
    } point_t;

    point_t due[$];
    int fails;
    int accepted;
    bit first_step;
    longint beta;
    longint unsigned lap_g, bilap_g;
    int cols, rows;
    longint lines[4][LINE_LEN];
    longint win[5][5];
    int col_pos, row_pos;

    function new();
      fails = 0;
      accepted = 0;
      first_step = 0;
      beta = 0;
      lap_g = 0;
      bilap_g = 0;
      cols = 1024;
      rows = 1024;
      col_pos = 0;
      row_pos = 0;
      foreach (lines[i, j]) lines[i][j] = 0;
      foreach (win[i, j]) win[i][j] = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] d);
      case (idx)
        pfes_pkg::REG_FIRST_STEP: first_step = d[0];
        pfes_pkg::REG_BETA:       beta = longint'($signed(d[31:0]));
        pfes_pkg::REG_LAP_GAIN:   lap_g = 64'(d);
        pfes_pkg::REG_BILAP_GAIN: bilap_g = 64'(d);
        pfes_pkg::REG_GRID_COLS: begin
          cols = int'(d[10:0]);
          if (cols == 0) cols = 1;
          if (cols > 1024) cols = 1024;
          col_pos = 0;
          row_pos = 0;
        end
        pfes_pkg::REG_GRID_ROWS: begin
          rows = int'(d[12:0]);
          if (rows == 0) rows = 1;
          col_pos = 0;
          row_pos = 0;
        end
        default: ;
      endcase
    endfunction

    function longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint round_q(longint x);
      return (x + 64'sd8388608) >>> pfes_pkg::FRAC_BITS;
    endfunction

    function longint unsigned capped_mul(longint unsigned a, longint unsigned b,
                                         longint unsigned cap);
      longint unsigned p;
      if (b != 0 && a > cap / b) return cap;
      p = a * b;
      return (p > cap) ? cap : p;
    endfunction

    function longint unsigned gain_mag(longint unsigned a, longint unsigned g);
      longint unsigned hi, lo, m;
      hi = capped_mul(a, g >> pfes_pkg::FRAC_BITS, 64'd1 << 40);
      lo = capped_mul(a, g & ((64'd1 << pfes_pkg::FRAC_BITS) - 1), 64'd1 << 62);
      m = hi + ((lo + (64'd1 << (pfes_pkg::FRAC_BITS - 1))) >> pfes_pkg::FRAC_BITS);
      return (m > (64'd1 << 40)) ? (64'd1 << 40) : m;
    endfunction

    // nonlinear term (phi^2 - 1 - beta) * phi
    function longint cubic(longint p);
      longint p2, a;
      p2 = clip32(round_q(p * p));
      a = clip32(p2 - (64'sd1 <<< pfes_pkg::FRAC_BITS) - beta);
      return clip32(round_q(a * p));
    endfunction

    function longint nudge(longint phi, longint s, longint unsigned g, bit sub);
      longint d;
      d = longint'(gain_mag((s < 0) ? -s : s, g));
      if (s < 0) d = -d;
      if (sub) d = -d;
      return clip32(phi + d);
    endfunction

    function void note_item(logic [31:0] v);
      longint x, phi, lap, bl;
      int c, r, wd, ht;
      bit last;
      point_t p;
      x = longint'($signed(v));
      c = col_pos;
      r = row_pos;
      wd = cols + 4;
      ht = rows + 4;
      last = (r == ht - 1) && (c == wd - 1);
      accepted++;
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 4; j++) win[i][j] = win[i][j + 1];
        win[i][4] = (i < 4) ? lines[i][c] : x;
      end
      for (int i = 0; i < 3; i++) lines[i][c] = lines[i + 1][c];
      lines[3][c] = x;
      if (r >= 4 && c >= 4) begin
        phi = win[2][2];
        if (first_step) begin
          p.ex = phi[31:0];
          p.sm = phi[31:0];
        end else begin
          lap = cubic(win[1][2]) + cubic(win[3][2]) + cubic(win[2][1])
              + cubic(win[2][3]) - 4 * cubic(phi);
          bl = win[0][2] + win[4][2] + win[2][0] + win[2][4]
             + 2 * (win[1][1] + win[1][3] + win[3][1] + win[3][3])
             - 8 * (win[1][2] + win[3][2] + win[2][1] + win[2][3])
             + 20 * phi;
          p.ex = 32'(nudge(phi, lap, lap_g, 0));
          p.sm = 32'(nudge(phi, bl, bilap_g, 1));
        end
        p.last = last;
        due.push_back(p);
      end
      if (last || r >= ht) begin
        col_pos = 0;
        row_pos = 0;
      end else if (c + 1 >= wd) begin
        col_pos = 0;
        row_pos = r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void check(logic [31:0] ex, logic [31:0] sm, logic last);
      point_t p;
      if (due.size() == 0) begin
        if (fails < 10) $display("unexpected result ex=%h sm=%h last=%b", ex, sm, last);
        fails++;
        return;
      end
      p = due.pop_front();
      if (p.ex !== ex || p.sm !== sm || p.last !== last) begin
        if (fails < 10)
          $display("mismatch: expected ex=%h sm=%h last=%b, got ex=%h sm=%h last=%b",
                   p.ex, p.sm, p.last, ex, sm, last);
        fails++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [31:0] in_field_value = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] out_explicit_value;
  logic [31:0] out_sum_value;
  logic        out_frame_last;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;
  int          quiet_cycles = 0;

  stencil_scoreboard sb = new();

  phase_field_explicit_stencil_core DUT (
    .clk, .rst_n, .in_valid, .in_ready, .in_field_value,
    .out_valid, .out_ready, .out_explicit_value, .out_sum_value, .out_frame_last,
    .cfg_we, .cfg_index, .cfg_data
  );

  always #2 clk = ~clk;

  function int send_idle_pct();
    if (sb.accepted < TOTAL_ITEMS / 3) return 21;
    if (sb.accepted < 2 * TOTAL_ITEMS / 3) return 45;
    return 0;
  endfunction

  function int recv_stall_pct();
    if (sb.accepted < TOTAL_ITEMS / 3) return 45;
    if (sb.accepted < 2 * TOTAL_ITEMS / 3) return 21;
    return 0;
  endfunction

  // result side: check, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check(out_explicit_value, out_sum_value, out_frame_last);
    out_ready <= ($urandom_range(99) >= recv_stall_pct());
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function logic [31:0] pick_field();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      3: return 32'h0;
      default: return $urandom_range(0, 32'h4000000) - 32'h2000000;
    endcase
  endfunction

  function logic [47:0] pick_gain();
    case ($urandom_range(5))
      0: return 48'h0;
      1: return 48'hffffffffffff;
      2: return 48'({$urandom, $urandom});
      3: return 48'($urandom_range(0, 32'h4000000));
      default: return 48'($urandom_range(0, 32'h1000000));
    endcase
  endfunction

  function logic [47:0] pick_beta();
    case ($urandom_range(4))
      0: return {16'hffff, 32'h80000000};
      1: return {16'h0, 32'h7fffffff};
      2: return 48'({$urandom, $urandom});
      default: return {16'h0, $urandom_range(0, 32'h2000000) - 32'h1000000};
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [47:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    sb.write_reg(idx, d);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_items(logic [31:0] vals[$]);
    int gap;
    foreach (vals[i]) begin
      gap = 0;
      while ($urandom_range(99) < send_idle_pct()) gap++;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_field_value <= vals[i];
      do @(posedge clk); while (!in_ready);
      sb.note_item(vals[i]);
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.due.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_grid(int c, int r);
    write_reg(pfes_pkg::REG_GRID_COLS, 48'(c));
    write_reg(pfes_pkg::REG_GRID_ROWS, 48'(r));
  endtask

  initial begin
    logic [31:0] vals[$];
    int c, r, n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // saturating corner: extreme gains, beta and samples on a 1x1 grid
    write_reg(pfes_pkg::REG_FIRST_STEP, 48'h0);
    write_reg(pfes_pkg::REG_BETA, {16'h0, 32'h7fffffff});
    write_reg(pfes_pkg::REG_LAP_GAIN, 48'hffffffffffff);
    write_reg(pfes_pkg::REG_BILAP_GAIN, 48'hffffffffffff);
    set_grid(1, 1);
    vals = {};
    for (int i = 0; i < 25; i++)
      vals.push_back((i % 3 == 0) ? 32'h7fffffff : (i % 3 == 1) ? 32'h80000000 : 32'h0);
    push_items(vals);
    drain();

    // copy mode, min beta, junk in unused data bits, spare indexes ignored
    write_reg(pfes_pkg::REG_FIRST_STEP, 48'hfffffffffff1);
    write_reg(pfes_pkg::REG_BETA, {16'hffff, 32'h80000000});
    write_reg(REG_SPARE_A, 48'hffffffffffff);
    write_reg(REG_SPARE_B, 48'h000000000003);
    set_grid(0, 0);
    vals = {};
    for (int i = 0; i < 25; i++) vals.push_back(pick_field());
    push_items(vals);
    drain();

    // size clamps and largest sizes, partial frames only
    write_reg(pfes_pkg::REG_FIRST_STEP, 48'h0);
    write_reg(pfes_pkg::REG_LAP_GAIN, 48'h1000000);
    write_reg(pfes_pkg::REG_BILAP_GAIN, 48'h0100000);
    set_grid(11'h7ff, 13'h1fff);
    vals = {};
    for (int i = 0; i < 20; i++) vals.push_back(pick_field());
    push_items(vals);
    drain();
    set_grid(1, 4096);
    vals = {};
    for (int i = 0; i < 25; i++) vals.push_back(pick_field());
    push_items(vals);
    drain();

    while (sb.accepted < TOTAL_ITEMS) begin
      write_reg(pfes_pkg::REG_FIRST_STEP, 48'({$urandom, $urandom} & 48'hfffffffffffe
                | ($urandom_range(9) == 0)));
      write_reg(pfes_pkg::REG_BETA, pick_beta());
      write_reg(pfes_pkg::REG_LAP_GAIN, pick_gain());
      write_reg(pfes_pkg::REG_BILAP_GAIN, pick_gain());
      c = ($urandom_range(7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      r = $urandom_range(1, 4);
      set_grid(c, r);
      n = (c + 4) * (r + 4);
      case ($urandom_range(9))
        0: n = $urandom_range(1, n - 1);
        1: n = n + $urandom_range(1, n);
        default: ;
      endcase
      vals = {};
      for (int i = 0; i < n; i++) vals.push_back(pick_field());
      push_items(vals);
      drain();
    end

    if (sb.fails == 0 && sb.due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
